// ----- rtl/microwire_eeprom_word_master_unit_macros.svh -----
// assertion helpers for the microwire word master checks
// each expects clk and rst to be visible where it is used
`ifndef MICROWIRE_EEPROM_WORD_MASTER_UNIT_MACROS_SVH
`define MICROWIRE_EEPROM_WORD_MASTER_UNIT_MACROS_SVH

// same-cycle implication, idle during reset
`define MWE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("microwire master check failed");

// next-cycle implication, idle during reset
`define MWE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("microwire master check failed");

`endif

// ----- rtl/mwe_pkg.sv -----
package mwe_pkg;

  // data and field widths
  localparam int DATA_BITS  = 16;
  localparam int WORD_W     = 16;
  localparam int ADDR_W     = 10;
  localparam int ABITS_W    = 4;
  localparam int TMO_W      = 8;
  localparam int RETRY_W    = 3;
  localparam int BITCNT_W   = 6;
  localparam int SHIFT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // address width limits
  localparam logic [ABITS_W-1:0] ABITS_MIN = 4'd6;
  localparam logic [ABITS_W-1:0] ABITS_MAX = 4'd10;

  // register reset values
  localparam logic [ABITS_W-1:0] ABITS_RST = 4'd6;
  localparam logic [TMO_W-1:0]   TMO_RST   = 8'd20;
  localparam logic [RETRY_W-1:0] RETRY_RST = 3'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd2;

  // item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // memory opcodes
  localparam logic [1:0] OP_EWEN  = 2'b00;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_READ  = 2'b10;

  // input word
  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] word_address;
    logic [WORD_W-1:0] write_data;
    logic              serial_in;
  } item_t;

  // result word
  typedef struct packed {
    logic              chip_select;
    logic              clock_pulse;
    logic              serial_out;
    logic              busy_res;
    logic              done_res;
    logic [WORD_W-1:0] read_word;
    logic              failed;
  } result_t;

endpackage

// ----- rtl/mwe_in_stage.sv -----
module mwe_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mwe_pkg::item_t in_item,
  input  logic          step,
  output logic          held_valid,
  output mwe_pkg::item_t held_item
);
  import mwe_pkg::*;

  // free slot, or the held word moves on this cycle
  assign in_ready = !held_valid || step;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- rtl/mwe_core.sv -----
module mwe_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             step,
  input  mwe_pkg::item_t                   item,
  output mwe_pkg::result_t                 res
);
  import mwe_pkg::*;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_EWEN      = 10'b00_0000_0010,
    PH_EWEN_GAP  = 10'b00_0000_0100,
    PH_WRITE     = 10'b00_0000_1000,
    PH_WRITE_GAP = 10'b00_0001_0000,
    PH_POLL      = 10'b00_0010_0000,
    PH_POLL_GAP  = 10'b00_0100_0000,
    PH_READ      = 10'b00_1000_0000,
    PH_RECEIVE   = 10'b01_0000_0000,
    PH_RETRY_GAP = 10'b10_0000_0000
  } phase_t;

  // left-aligned frame: start bit, opcode, address, optional data
  function automatic logic [SHIFT_W-1:0] frame_word(
    input logic [1:0]           op,
    input logic [ADDR_W-1:0]    addr,
    input logic [DATA_BITS-1:0] data,
    input logic                 with_data,
    input logic [ABITS_W-1:0]   ab
  );
    logic [ADDR_W-1:0]  amask;
    logic [SHIFT_W-1:0] f;
    amask = ~({ADDR_W{1'b1}} << ab);
    f = {1'b1, op, {(SHIFT_W-3){1'b0}}};
    f = f | (SHIFT_W'(addr & amask) << (6'd29 - {2'b0, ab}));
    if (with_data) begin
      f = f | (SHIFT_W'(data) << (6'd29 - {2'b0, ab} - 6'(DATA_BITS)));
    end
    return f;
  endfunction

  function automatic logic [BITCNT_W-1:0] frame_len(
    input logic               with_data,
    input logic [ABITS_W-1:0] ab
  );
    return 6'd3 + {2'b0, ab} + (with_data ? 6'(DATA_BITS) : 6'd0);
  endfunction

  // configuration
  logic [ABITS_W-1:0] address_bits;
  logic [TMO_W-1:0]   ready_timeout;
  logic [RETRY_W-1:0] retry_limit;

  // transaction state
  phase_t               phase, phase_next;
  logic [BITCNT_W-1:0]  bit_count, bit_count_next;
  logic [SHIFT_W-1:0]   shift_word, shift_word_next;
  logic [ADDR_W-1:0]    held_address, held_address_next;
  logic [DATA_BITS-1:0] held_data, held_data_next;
  logic                 is_write, is_write_next;
  logic [RETRY_W-1:0]   attempt_count, attempt_count_next;
  logic [TMO_W-1:0]     wait_count, wait_count_next;
  logic [DATA_BITS-1:0] received_word, received_word_next;

  logic [ABITS_W-1:0]   ab;
  logic [TMO_W-1:0]     tmo;
  logic [RETRY_W-1:0]   lim;
  logic [ADDR_W-1:0]    ewen_addr;
  logic [BITCNT_W-1:0]  count_dec;
  logic                 cs_level;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      address_bits  <= ABITS_RST;
      ready_timeout <= TMO_RST;
      retry_limit   <= RETRY_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ADDRESS_BITS:  address_bits  <= cfg_data[ABITS_W-1:0];
        CFG_READY_TIMEOUT: ready_timeout <= cfg_data[TMO_W-1:0];
        CFG_RETRY_LIMIT:   retry_limit   <= cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // effective settings
  always_comb begin
    if (address_bits < ABITS_MIN) begin
      ab = ABITS_MIN;
    end else if (address_bits > ABITS_MAX) begin
      ab = ABITS_MAX;
    end else begin
      ab = address_bits;
    end
    tmo = (ready_timeout == '0) ? TMO_W'(1) : ready_timeout;
    lim = (retry_limit == '0) ? RETRY_W'(1) : retry_limit;
    // write-enable frame sets the top two address bits
    ewen_addr = ADDR_W'(3) << (ab - 4'd2);
    count_dec = (bit_count != '0) ? bit_count - 6'd1 : '0;
  end

  // chip select level of the current phase
  always_comb begin
    unique case (phase)
      PH_EWEN, PH_WRITE, PH_POLL, PH_READ, PH_RECEIVE: cs_level = 1'b1;
      default:                                         cs_level = 1'b0;
    endcase
  end

  // one step per accepted word
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_word_next    = shift_word;
    held_address_next  = held_address;
    held_data_next     = held_data;
    is_write_next      = is_write;
    attempt_count_next = attempt_count;
    wait_count_next    = wait_count;
    received_word_next = received_word;
    res = '0;

    if (phase == PH_IDLE) begin
      if (item.kind == KIND_READ || item.kind == KIND_WRITE) begin
        held_address_next  = item.word_address;
        held_data_next     = item.write_data[DATA_BITS-1:0];
        is_write_next      = (item.kind == KIND_WRITE);
        attempt_count_next = '0;
        wait_count_next    = '0;
        received_word_next = '0;
        if (item.kind == KIND_WRITE) begin
          shift_word_next = frame_word(OP_EWEN, ewen_addr, '0, 1'b0, ab);
          bit_count_next  = frame_len(1'b0, ab);
          phase_next      = PH_EWEN;
        end else begin
          shift_word_next = frame_word(OP_READ, item.word_address, '0, 1'b0, ab);
          bit_count_next  = frame_len(1'b0, ab);
          phase_next      = PH_READ;
        end
      end
    end else if (item.kind != KIND_TICK) begin
      // start or unknown kind while busy: ignored
      res.chip_select = cs_level;
    end else begin
      unique case (phase)
        PH_EWEN, PH_WRITE, PH_READ: begin
          res.chip_select = 1'b1;
          res.clock_pulse = 1'b1;
          res.serial_out  = shift_word[SHIFT_W-1];
          shift_word_next = shift_word << 1;
          bit_count_next  = count_dec;
          if (count_dec == '0) begin
            if (phase == PH_EWEN) begin
              phase_next = PH_EWEN_GAP;
            end else if (phase == PH_WRITE) begin
              phase_next = PH_WRITE_GAP;
            end else begin
              phase_next         = PH_RECEIVE;
              bit_count_next     = BITCNT_W'(DATA_BITS);
              received_word_next = '0;
            end
          end
        end
        PH_EWEN_GAP: begin
          shift_word_next = frame_word(OP_WRITE, held_address, held_data, 1'b1, ab);
          bit_count_next  = frame_len(1'b1, ab);
          phase_next      = PH_WRITE;
        end
        PH_WRITE_GAP: begin
          wait_count_next = '0;
          phase_next      = PH_POLL;
        end
        PH_POLL: begin
          res.chip_select = 1'b1;
          if (item.serial_in) begin
            phase_next = PH_POLL_GAP;
          end else begin
            wait_count_next = wait_count + 8'd1;
            if (wait_count_next >= tmo) begin
              phase_next = PH_POLL_GAP;
            end
          end
        end
        PH_POLL_GAP: begin
          shift_word_next = frame_word(OP_READ, held_address, '0, 1'b0, ab);
          bit_count_next  = frame_len(1'b0, ab);
          phase_next      = PH_READ;
        end
        PH_RETRY_GAP: begin
          shift_word_next = frame_word(OP_EWEN, ewen_addr, '0, 1'b0, ab);
          bit_count_next  = frame_len(1'b0, ab);
          phase_next      = PH_EWEN;
        end
        PH_RECEIVE: begin
          res.chip_select    = 1'b1;
          res.clock_pulse    = 1'b1;
          received_word_next = {received_word[DATA_BITS-2:0], item.serial_in};
          bit_count_next     = count_dec;
          if (count_dec == '0) begin
            if (!is_write || received_word_next == held_data) begin
              res.done_res  = 1'b1;
              res.read_word = WORD_W'(received_word_next);
              phase_next    = PH_IDLE;
            end else begin
              attempt_count_next = attempt_count + 3'd1;
              if (attempt_count_next >= lim) begin
                res.done_res  = 1'b1;
                res.read_word = WORD_W'(received_word_next);
                res.failed    = 1'b1;
                phase_next    = PH_IDLE;
              end else begin
                phase_next = PH_RETRY_GAP;
              end
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    res.busy_res = (phase_next != PH_IDLE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      attempt_count <= '0;
      wait_count    <= '0;
      is_write      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      attempt_count <= attempt_count_next;
      wait_count    <= wait_count_next;
      is_write      <= is_write_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (step) begin
      shift_word    <= shift_word_next;
      held_address  <= held_address_next;
      held_data     <= held_data_next;
      received_word <= received_word_next;
    end
  end

endmodule

// ----- rtl/mwe_out_stage.sv -----
module mwe_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  mwe_pkg::result_t res_in,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output mwe_pkg::result_t res_out
);
  import mwe_pkg::*;

  // room for a new result when empty or being drained
  assign take = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && take) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- rtl/microwire_eeprom_word_master_unit.sv -----
// Microwire EEPROM word master, x16 organisation. Each input word is either a
// start (read or write) or one serial bit slot from the caller's clock divider;
// every accepted word yields exactly one result word with the chip select,
// clock pulse and data-in levels for that slot plus busy and done status.
// One word is taken per clock cycle when the output side keeps up; each word
// passes the input register, then the step logic into the result register,
// and the rate is set by the single state update per word. Registers:
// 0 address bits (6..10), 1 ready timeout in poll slots, 2 write retry limit;
// write them only while the block is idle.
module microwire_eeprom_word_master_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mwe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [mwe_pkg::ADDR_W-1:0]        word_address,
  input  logic [mwe_pkg::WORD_W-1:0]        write_data,
  input  logic                              serial_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              chip_select,
  output logic                              clock_pulse,
  output logic                              serial_out,
  output logic                              busy_res,
  output logic                              done_res,
  output logic [mwe_pkg::WORD_W-1:0]        read_word,
  output logic                              failed
);
  import mwe_pkg::*;

  item_t   in_item, held_item;
  result_t step_res, out_res;
  logic    held_valid, take, step;

  assign in_item = '{kind: kind, word_address: word_address,
                     write_data: write_data, serial_in: serial_in};

  // a held word steps when the result register has room
  assign step = held_valid && take;

  mwe_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .step       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mwe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (held_item),
    .res       (step_res)
  );

  mwe_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .res_in    (step_res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  // result fields
  assign chip_select = out_res.chip_select;
  assign clock_pulse = out_res.clock_pulse;
  assign serial_out  = out_res.serial_out;
  assign busy_res    = out_res.busy_res;
  assign done_res    = out_res.done_res;
  assign read_word   = out_res.read_word;
  assign failed      = out_res.failed;

endmodule

// ----- rtl/mwe_checker.sv -----
`include "microwire_eeprom_word_master_unit_macros.svh"

module mwe_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       chip_select,
  input logic                       clock_pulse,
  input logic                       serial_out,
  input logic                       busy_res,
  input logic                       done_res,
  input logic [mwe_pkg::WORD_W-1:0] read_word,
  input logic                       failed
);
  import mwe_pkg::*;

  // a finished transaction leaves the master idle
  `MWE_ASSERT_IMPL(a_done_not_busy, out_valid && done_res, !busy_res)

  // word and failure flag are zero unless done
  `MWE_ASSERT_IMPL(a_word_only_done, out_valid && !done_res, read_word == '0 && !failed)

  // clock pulses only with chip select
  `MWE_ASSERT_IMPL(a_clock_in_frame, out_valid && clock_pulse, chip_select)

  // data-in is only driven on a clocked slot
  `MWE_ASSERT_IMPL(a_data_with_clock, out_valid && serial_out, clock_pulse)

  // a stalled result holds
  `MWE_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(read_word) && $stable(done_res))

endmodule

bind microwire_eeprom_word_master_unit mwe_checker u_mwe_checker (.*);
